>>> design/spl_pkg.sv
// ---------------------------------------------------------------------------
// spl_pkg: shared types and constants of the stereo peak limiter
// Field widths, register indexes and reset values of the control registers.
// ---------------------------------------------------------------------------
package spl_pkg;

    localparam int ENV_W      = 32;   // envelope word, unsigned fixed point
    localparam int THR_W      = 24;   // threshold register width
    localparam int COEFF_W    = 24;   // release coefficient, Q0.24
    localparam int COEFF_FRAC = 24;
    localparam int MAKEUP_W   = 18;   // makeup gain, Q2.16
    localparam int GAIN_FRAC  = 16;   // fraction bits of both gains
    localparam int GAIN_W     = 17;   // reduction gain, Q0.16 plus the unity bit
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_THRESHOLD = 2'd0;
    localparam cfg_idx_t REG_RELEASE   = 2'd1;
    localparam cfg_idx_t REG_MAKEUP    = 2'd2;

    localparam logic [THR_W-1:0]    THRESHOLD_RST = 24'h800000;
    localparam logic [COEFF_W-1:0]  RELEASE_RST   = 24'hFFF259;
    localparam logic [MAKEUP_W-1:0] MAKEUP_RST    = 18'h10000;
    localparam logic [GAIN_W-1:0]   UNITY_GAIN    = 17'h10000;

endpackage

>>> design/stereo_peak_limiter.sv
// ---------------------------------------------------------------------------
// stereo_peak_limiter: linked stereo peak limiter
// Instant attack, exponential release, gain = threshold / envelope above the
// threshold, then makeup gain and saturation on both channels.
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------
//   sample    sample_valid/sample_stall  left_in, right_in
//   result    result_valid/result_stall  left_out, right_out, gain_applied
//   cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A word passes envelope decay, the divider (only above the threshold), gain
// scaling and makeup gain before its result is loaded; the next word is taken
// once the block is idle again. The bit-serial units take 24 steps of envelope
// decay, 16 divider steps, 17 steps of gain scaling and 18 of makeup gain.
// Reset clears the envelope and loads the register defaults; cfg_ready is
// always high. A stalled result waits in the output register.
// ---------------------------------------------------------------------------
module stereo_peak_limiter
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS   = 24,
    parameter int ENV_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic        [GAIN_W-1:0]      gain_applied,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   cfg_index,
    input  logic        [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PEAK_W  = SAMPLE_BITS + ENV_FRAC_BITS;
    localparam int PK_CMP_W = (PEAK_W > ENV_W) ? PEAK_W : ENV_W;
    localparam int THRS_W  = THR_W + ENV_FRAC_BITS;
    localparam int CMP_W   = (THRS_W > ENV_W) ? THRS_W : ENV_W;
    localparam int U_W     = SAMPLE_BITS + 2;

    localparam logic [PK_CMP_W-1:0] ENV_MAX_CMP = PK_CMP_W'({ENV_W{1'b1}});
    localparam logic [U_W-1:0] POS_MAX = U_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [U_W-1:0] NEG_MAX = U_W'(64'd1 << (SAMPLE_BITS - 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECAY,
        S_ENV,
        S_DIV,
        S_SCALE,
        S_MAKEUP,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [THR_W-1:0]    threshold_reg;
    logic [COEFF_W-1:0]  coeff_reg;
    logic [MAKEUP_W-1:0] makeup_reg;
    logic [ENV_W-1:0]    env_reg;

    logic [SAMPLE_BITS-1:0] mag_reg [2];
    logic                   neg_reg [2];
    logic [ENV_W-1:0]       peak_reg;
    logic [GAIN_W-1:0]      gain_reg;

    logic dec_start_reg;
    logic div_start_reg;
    logic sc_start_reg;
    logic mk_start_reg;

    logic                          result_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic [GAIN_W-1:0]             gain_out_reg;

    logic [SAMPLE_BITS-1:0] lane_in  [2];
    logic [SAMPLE_BITS-1:0] lane_mag [2];
    logic [ENV_W-1:0]       peak_sat;
    logic [ENV_W-1:0]       dec_p;
    logic                   dec_done;
    logic [ENV_W-1:0]       env_new;
    logic [CMP_W-1:0]       thr_cmp;
    logic                   div_done;
    logic [GAIN_FRAC-1:0]   div_quo;
    logic [SAMPLE_BITS-1:0] sc_p     [2];
    logic [1:0]             sc_done;
    logic [U_W-1:0]         mk_p     [2];
    logic [1:0]             mk_done;
    logic [SAMPLE_BITS-1:0] lim_out  [2];

    assign lane_in[0] = left_in;
    assign lane_in[1] = right_in;

    // Magnitudes and the linked peak, saturated into the envelope format.
    always_comb
    begin
        logic [SAMPLE_BITS-1:0] pk;
        logic [PK_CMP_W-1:0]    pk_wide;
        for (int ln = 0; ln < 2; ln++)
        begin
            lane_mag[ln] = lane_in[ln][SAMPLE_BITS-1] ? ('0 - lane_in[ln]) : lane_in[ln];
        end
        pk      = (lane_mag[0] > lane_mag[1]) ? lane_mag[0] : lane_mag[1];
        pk_wide = PK_CMP_W'(PK_CMP_W'(pk) << ENV_FRAC_BITS);
        peak_sat = (pk_wide > ENV_MAX_CMP) ? {ENV_W{1'b1}} : ENV_W'(pk_wide);
    end

    assign env_new = (peak_reg > dec_p) ? peak_reg : dec_p;
    assign thr_cmp = CMP_W'(CMP_W'(threshold_reg) << ENV_FRAC_BITS);

    // Magnitudes come rounded to nearest; saturate them, then restore the sign.
    always_comb
    begin
        logic [U_W-1:0] lim;
        for (int ln = 0; ln < 2; ln++)
        begin
            if (neg_reg[ln])
            begin
                lim = (mk_p[ln] > NEG_MAX) ? NEG_MAX : mk_p[ln];
                lim_out[ln] = SAMPLE_BITS'(U_W'(0) - lim);
            end
            else
            begin
                lim = (mk_p[ln] > POS_MAX) ? POS_MAX : mk_p[ln];
                lim_out[ln] = SAMPLE_BITS'(lim);
            end
        end
    end

    spl_serial_mul #(
        .A_W   (ENV_W),
        .B_W   (COEFF_W),
        .SHIFT (COEFF_FRAC),
        .ROUND (0),
        .P_W   (ENV_W)
    ) u_decay (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dec_start_reg),
        .a     (env_reg),
        .b     (coeff_reg),
        .done  (dec_done),
        .p     (dec_p)
    );

    spl_gain_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (ENV_W'(thr_cmp)),
        .den   (env_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        spl_serial_mul #(
            .A_W   (SAMPLE_BITS),
            .B_W   (GAIN_W),
            .SHIFT (GAIN_FRAC),
            .ROUND (1),
            .P_W   (SAMPLE_BITS)
        ) u_scale (
            .clk   (clk),
            .rst_n (rst_n),
            .start (sc_start_reg),
            .a     (mag_reg[ln]),
            .b     (gain_reg),
            .done  (sc_done[ln]),
            .p     (sc_p[ln])
        );

        spl_serial_mul #(
            .A_W   (SAMPLE_BITS),
            .B_W   (MAKEUP_W),
            .SHIFT (GAIN_FRAC),
            .ROUND (1),
            .P_W   (U_W)
        ) u_makeup (
            .clk   (clk),
            .rst_n (rst_n),
            .start (mk_start_reg),
            .a     (sc_p[ln]),
            .b     (makeup_reg),
            .done  (mk_done[ln]),
            .p     (mk_p[ln])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            coeff_reg     <= RELEASE_RST;
            makeup_reg    <= MAKEUP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_RELEASE:   coeff_reg     <= cfg_data[COEFF_W-1:0];
                REG_MAKEUP:    makeup_reg    <= cfg_data[MAKEUP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample_valid)
        begin
            for (int ln = 0; ln < 2; ln++)
            begin
                mag_reg[ln] <= lane_mag[ln];
                neg_reg[ln] <= lane_in[ln][SAMPLE_BITS-1];
            end
            peak_reg <= peak_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            env_reg          <= '0;
            gain_reg         <= UNITY_GAIN;
            dec_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            sc_start_reg     <= 1'b0;
            mk_start_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            left_out_reg     <= '0;
            right_out_reg    <= '0;
            gain_out_reg     <= '0;
        end
        else
        begin
            dec_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            sc_start_reg  <= 1'b0;
            mk_start_reg  <= 1'b0;
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        dec_start_reg <= 1'b1;
                        state_reg     <= S_DECAY;
                    end
                end
                S_DECAY:
                begin
                    if (dec_done)
                    begin
                        state_reg <= S_ENV;
                    end
                end
                S_ENV:
                begin
                    env_reg <= env_new;
                    // Only an envelope strictly above the threshold limits.
                    if (CMP_W'(env_new) > thr_cmp)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                    else
                    begin
                        gain_reg     <= UNITY_GAIN;
                        sc_start_reg <= 1'b1;
                        state_reg    <= S_SCALE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        gain_reg     <= GAIN_W'(div_quo);
                        sc_start_reg <= 1'b1;
                        state_reg    <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (&sc_done)
                    begin
                        mk_start_reg <= 1'b1;
                        state_reg    <= S_MAKEUP;
                    end
                end
                S_MAKEUP:
                begin
                    if (&mk_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        left_out_reg     <= lim_out[0];
                        right_out_reg    <= lim_out[1];
                        gain_out_reg     <= gain_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;
    assign gain_applied = gain_out_reg;

endmodule

>>> design/spl_serial_mul.sv
// ---------------------------------------------------------------------------
// spl_serial_mul: bit-serial shift-and-add multiplier
// Computes (a * b [+ 2^(SHIFT-1)]) >> SHIFT, taking one bit of b per cycle,
// least significant first. The low SHIFT partial sums are shifted right so
// the adder stays only as wide as the result.
// ---------------------------------------------------------------------------
module spl_serial_mul #(
    parameter int A_W   = 32,
    parameter int B_W   = 24,
    parameter int SHIFT = 24,
    parameter int ROUND = 0,
    parameter int P_W   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] p
);

    localparam int CNT_W = $clog2(B_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(B_W - 1);
    localparam logic [CNT_W-1:0] ROUND_STEP = CNT_W'(SHIFT - 1);
    localparam logic [CNT_W-1:0] SHIFT_END  = CNT_W'(SHIFT);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [P_W-1:0]   mc_reg, mc_next;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [P_W-1:0] addend;
    logic [P_W:0]   sum;
    logic           rnd;

    always_comb
    begin
        addend = b_reg[0] ? mc_reg : '0;
        // Adding one at weight 2^(SHIFT-1) gives round half up on the final shift.
        rnd    = (ROUND != 0) && (cnt_reg == ROUND_STEP);
        sum    = {1'b0, acc_reg} + {1'b0, addend} + (P_W + 1)'(rnd);
        if (cnt_reg < SHIFT_END)
        begin
            acc_next = sum[P_W:1];
            mc_next  = mc_reg;
        end
        else
        begin
            // Multiplier bits above the shifted part weigh the multiplicand up.
            acc_next = sum[P_W-1:0];
            mc_next  = mc_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= P_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            mc_reg  <= mc_next;
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> design/spl_gain_div.sv
// ---------------------------------------------------------------------------
// spl_gain_div: restoring divider for the reduction gain
// Forms floor(num * 2^16 / den), one quotient bit per cycle. The caller only
// starts it with num below den, so the quotient always fits in 16 bits.
// ---------------------------------------------------------------------------
module spl_gain_div
    import spl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ENV_W-1:0]     num,
    input  logic [ENV_W-1:0]     den,
    output logic                 done,
    output logic [GAIN_FRAC-1:0] quo
);

    localparam int CNT_W = $clog2(GAIN_FRAC);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_FRAC - 1);

    logic [ENV_W-1:0]     rem_reg, rem_next;
    logic [ENV_W-1:0]     den_reg;
    logic [GAIN_FRAC-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [ENV_W:0] trial;
    logic           take;

    always_comb
    begin
        trial = {rem_reg, 1'b0};
        take  = trial >= {1'b0, den_reg};
        // The remainder stays below the divisor, so both arms fit the word.
        rem_next = take ? ENV_W'(trial - {1'b0, den_reg}) : trial[ENV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[GAIN_FRAC-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> design/spl_checker.sv
// ---------------------------------------------------------------------------
// spl_checker: port-level checks for the stereo peak limiter
// Watches the sample and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module spl_checker
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic signed [SAMPLE_BITS-1:0] left_out,
    input logic signed [SAMPLE_BITS-1:0] right_out,
    input logic        [GAIN_W-1:0]      gain_applied
);

    // A stalled result word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(left_out) && $stable(right_out)
            && $stable(gain_applied))
    else $error("stalled result word changed or was dropped");

    // The reduction gain never exceeds unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> gain_applied <= UNITY_GAIN)
    else $error("gain above unity");

    // A zero gain silences both channels whatever the makeup gain.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && gain_applied == '0 |-> left_out == '0 && right_out == '0)
    else $error("output not silent at zero gain");

    // Once a sample word is taken the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
    else $error("second sample word taken while the first is in work");

endmodule

bind stereo_peak_limiter spl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_spl_checker (.*);
